// ===== design/fpc_pkg.sv =====
// package for the frustum plane cull test: widths, codes, state and control types
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package fpc_pkg;

    // defaults for the top-level parameters
    localparam int NUM_PLANES_DEF       = 6;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // fixed field widths
    localparam int COORD_W   = 24;
    localparam int WVAL_W    = 32;
    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 3;
    localparam int VERDICT_W = 2;
    localparam int STEP_W    = 3;

    // stream bus widths
    localparam int IN_TDATA_W  = 176;
    localparam int IN_TUSER_W  = MODE_W + INDEX_W;
    localparam int OUT_TDATA_W = 8;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPHERE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOX    = 2'd2;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_CROSSING = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_INSIDE   = 2'd2;

    // multiply terms per plane
    localparam logic [STEP_W-1:0] SPHERE_TERMS = 3'd3;
    localparam logic [STEP_W-1:0] BOX_TERMS    = 3'd6;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic init;
        logic mul_en;
        logic add_en;
        logic add_sel;
    } mac_ctrl_t;

    typedef struct packed {
        logic pos_below;
        logic neg_below;
    } mac_stat_t;

endpackage

// ===== design/fpc_plane_store.sv =====
// plane register file: normals and offsets, one write port, one read port
// depends on fpc_pkg
`timescale 1ns / 1ps

module fpc_plane_store #(
    parameter int NUM_PLANES       = fpc_pkg::NUM_PLANES_DEF,
    parameter int NORMAL_FRAC_BITS = fpc_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          wr_en,
    input  logic [fpc_pkg::INDEX_W-1:0]                   wr_idx,
    input  logic [2:0][NORMAL_FRAC_BITS+1:0]              wr_normal,
    input  logic [fpc_pkg::WVAL_W-1:0]                    wr_offset,
    input  logic [((NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1)-1:0] rd_idx,
    output logic [2:0][NORMAL_FRAC_BITS+1:0]              rd_normal,
    output logic [fpc_pkg::WVAL_W-1:0]                    rd_offset
);

    logic [2:0][NORMAL_FRAC_BITS+1:0] normal_reg [NUM_PLANES];
    logic [fpc_pkg::WVAL_W-1:0]       offset_reg [NUM_PLANES];

    // slots past the plane count never match, so such loads drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_PLANES; e++)
            begin
                normal_reg[e] <= '0;
                offset_reg[e] <= '0;
            end
        end
        else
        begin
            for (int e = 0; e < NUM_PLANES; e++)
            begin
                if (wr_en && (32'(wr_idx) == 32'(e)))
                begin
                    normal_reg[e] <= wr_normal;
                    offset_reg[e] <= wr_offset;
                end
            end
        end
    end

    assign rd_normal = normal_reg[rd_idx];
    assign rd_offset = offset_reg[rd_idx];

endmodule

// ===== design/fpc_mac.sv =====
// shared multiply-accumulate unit with two accumulators (positive and negative corner)
// depends on fpc_pkg
`timescale 1ns / 1ps

module fpc_mac #(
    parameter int NORMAL_FRAC_BITS = fpc_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  fpc_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [NORMAL_FRAC_BITS+1:0]    mul_a,
    input  logic signed [fpc_pkg::COORD_W-1:0]    mul_b,
    input  logic signed [fpc_pkg::WVAL_W-1:0]     offset,
    input  logic signed [fpc_pkg::WVAL_W-1:0]     extra,
    output fpc_pkg::mac_stat_t                    stat
);

    localparam int NORM_W = NORMAL_FRAC_BITS + 2;
    localparam int PROD_W = NORM_W + fpc_pkg::COORD_W;
    localparam int ACC_W  = NORMAL_FRAC_BITS + 35;

    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [ACC_W-1:0]            acc0_reg;
    logic signed [ACC_W-1:0]            acc1_reg;
    logic signed [fpc_pkg::WVAL_W:0]    base_sum;
    logic signed [ACC_W-1:0]            acc0_init;
    logic signed [ACC_W-1:0]            acc1_init;
    logic signed [ACC_W-1:0]            acc_add;

    // offsets brought to the product scale
    always_comb
    begin
        base_sum  = (fpc_pkg::WVAL_W+1)'(offset) + (fpc_pkg::WVAL_W+1)'(extra);
        acc0_init = ACC_W'(base_sum) <<< NORMAL_FRAC_BITS;
        acc1_init = ACC_W'(offset) <<< NORMAL_FRAC_BITS;
        acc_add   = (ctrl.add_sel ? acc1_reg : acc0_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.init)
        begin
            acc0_reg <= acc0_init;
            acc1_reg <= acc1_init;
        end
        else if (ctrl.add_en)
        begin
            if (ctrl.add_sel)
            begin
                acc1_reg <= acc_add;
            end
            else
            begin
                acc0_reg <= acc_add;
            end
        end
    end

    assign stat.pos_below = acc0_reg[ACC_W-1];
    assign stat.neg_below = acc1_reg[ACC_W-1];

endmodule

// ===== design/fpc_ctrl.sv =====
// sequencer: item registers, plane and term counters, operand select, result register
// depends on fpc_pkg; drives fpc_mac and reads fpc_plane_store
`timescale 1ns / 1ps

module fpc_ctrl #(
    parameter int NUM_PLANES       = fpc_pkg::NUM_PLANES_DEF,
    parameter int NORMAL_FRAC_BITS = fpc_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [fpc_pkg::MODE_W-1:0]                    mode,
    input  logic signed [fpc_pkg::COORD_W-1:0]            val_x,
    input  logic signed [fpc_pkg::COORD_W-1:0]            val_y,
    input  logic signed [fpc_pkg::COORD_W-1:0]            val_z,
    input  logic signed [fpc_pkg::WVAL_W-1:0]             val_w,
    input  logic signed [fpc_pkg::COORD_W-1:0]            ext_x,
    input  logic signed [fpc_pkg::COORD_W-1:0]            ext_y,
    input  logic signed [fpc_pkg::COORD_W-1:0]            ext_z,
    output logic [((NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1)-1:0] plane_idx,
    input  logic [2:0][NORMAL_FRAC_BITS+1:0]              plane_normal,
    output fpc_pkg::mac_ctrl_t                            mac_ctrl,
    output logic signed [NORMAL_FRAC_BITS+1:0]            mul_a,
    output logic signed [fpc_pkg::COORD_W-1:0]            mul_b,
    output logic signed [fpc_pkg::WVAL_W-1:0]             extra,
    input  fpc_pkg::mac_stat_t                            mac_stat,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [fpc_pkg::VERDICT_W-1:0]                 verdict,
    output logic                                          accepted
);

    localparam int NORM_W  = NORMAL_FRAC_BITS + 2;
    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    fpc_pkg::state_t                    state_reg;
    fpc_pkg::state_t                    state_next;

    logic                               box_reg;
    logic signed [fpc_pkg::COORD_W-1:0] lo_reg [3];
    logic signed [fpc_pkg::COORD_W-1:0] hi_reg [3];
    logic signed [fpc_pkg::WVAL_W-1:0]  w_reg;
    logic [PLANE_W-1:0]                 plane_reg;
    logic [PLANE_W-1:0]                 plane_next;
    logic [fpc_pkg::STEP_W-1:0]         step_reg;
    logic [fpc_pkg::STEP_W-1:0]         step_next;
    logic                               crossing_reg;
    logic                               crossing_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [fpc_pkg::VERDICT_W-1:0]      verdict_reg;
    logic [fpc_pkg::VERDICT_W-1:0]      verdict_next;

    logic                               run;
    logic                               accept_test;
    logic [fpc_pkg::STEP_W-1:0]         terms;
    logic                               check;
    logic                               outside;
    logic                               neg_below;
    logic                               last_plane;
    logic                               finish;
    logic                               done;
    logic                               advance;
    logic [1:0]                         k;
    logic signed [NORM_W-1:0]           n;
    logic signed [fpc_pkg::COORD_W-1:0] lo_k;
    logic signed [fpc_pkg::COORD_W-1:0] hi_k;
    logic                               take_hi;

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpc_pkg::ST_IDLE:
            begin
                if (accept_test)
                begin
                    state_next = fpc_pkg::ST_RUN;
                end
            end
            fpc_pkg::ST_RUN:
            begin
                if (done)
                begin
                    state_next = fpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpc_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready = 1'b0;
        run      = 1'b0;
        unique case (state_reg)
            fpc_pkg::ST_IDLE: in_ready = 1'b1;
            fpc_pkg::ST_RUN:  run      = 1'b1;
            default:          in_ready = 1'b0;
        endcase
    end

    // per plane: step 0 loads the offsets, steps 0..terms-1 multiply,
    // steps 1..terms accumulate, step terms+1 reads the signs
    always_comb
    begin
        accept_test = in_valid && in_ready &&
                      ((mode == fpc_pkg::MODE_SPHERE) || (mode == fpc_pkg::MODE_BOX));
        terms       = box_reg ? fpc_pkg::BOX_TERMS : fpc_pkg::SPHERE_TERMS;
        check       = run && (step_reg == terms + fpc_pkg::STEP_W'(1));
        outside     = check && mac_stat.pos_below;
        neg_below   = box_reg && mac_stat.neg_below;
        last_plane  = (plane_reg == PLANE_W'(NUM_PLANES - 1));
        finish      = check && (outside || last_plane);
        done        = finish && (!out_valid_reg || out_ready);
        advance     = check && !finish;

        // box terms alternate positive and negative corner per component
        k = box_reg ? step_reg[2:1] : step_reg[1:0];
        case (k)
            2'd0:
            begin
                n    = plane_normal[0];
                lo_k = lo_reg[0];
                hi_k = hi_reg[0];
            end
            2'd1:
            begin
                n    = plane_normal[1];
                lo_k = lo_reg[1];
                hi_k = hi_reg[1];
            end
            2'd2:
            begin
                n    = plane_normal[2];
                lo_k = lo_reg[2];
                hi_k = hi_reg[2];
            end
            default:
            begin
                n    = '0;
                lo_k = '0;
                hi_k = '0;
            end
        endcase
        take_hi = box_reg && (step_reg[0] ? n[NORM_W-1]
                                          : (!n[NORM_W-1] && (n != '0)));
        mul_a   = n;
        mul_b   = take_hi ? hi_k : lo_k;
        extra   = box_reg ? '0 : w_reg;

        mac_ctrl.init    = run && (step_reg == '0);
        mac_ctrl.mul_en  = run && (step_reg < terms);
        mac_ctrl.add_en  = run && (step_reg != '0) && (step_reg <= terms);
        mac_ctrl.add_sel = box_reg && !step_reg[0];

        step_next     = step_reg;
        plane_next    = plane_reg;
        crossing_next = crossing_reg;
        if (accept_test)
        begin
            step_next     = '0;
            plane_next    = '0;
            crossing_next = 1'b0;
        end
        else if (run && !check)
        begin
            step_next = step_reg + fpc_pkg::STEP_W'(1);
        end
        else if (advance)
        begin
            step_next     = '0;
            plane_next    = plane_reg + PLANE_W'(1);
            crossing_next = crossing_reg || neg_below;
        end

        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            if (outside)
            begin
                verdict_next = fpc_pkg::VERDICT_OUTSIDE;
            end
            else if (crossing_reg || neg_below)
            begin
                verdict_next = fpc_pkg::VERDICT_CROSSING;
            end
            else
            begin
                verdict_next = fpc_pkg::VERDICT_INSIDE;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpc_pkg::ST_IDLE;
            step_reg      <= '0;
            plane_reg     <= '0;
            crossing_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            plane_reg     <= plane_next;
            crossing_reg  <= crossing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        if (accept_test)
        begin
            box_reg   <= (mode == fpc_pkg::MODE_BOX);
            lo_reg[0] <= val_x;
            lo_reg[1] <= val_y;
            lo_reg[2] <= val_z;
            hi_reg[0] <= ext_x;
            hi_reg[1] <= ext_y;
            hi_reg[2] <= ext_z;
            w_reg     <= val_w;
        end
    end

    assign plane_idx = plane_reg;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign accepted  = (verdict_reg == fpc_pkg::VERDICT_INSIDE);

endmodule

// ===== design/frustum_plane_cull_test.sv =====
// sphere and box tests walk the planes in order; per plane the single shared multiplier
// takes one term a cycle, then the product register drains and a final step reads the signs
// a test ends early when a plane rejects; in_ready returns in the same cycle as result valid
// load items and ignored kinds are consumed in their accept cycle without starting a test;
// reset clears the plane store to zero and empties the result register
`timescale 1ns / 1ps

module frustum_plane_cull_test #(
    parameter int NUM_PLANES       = fpc_pkg::NUM_PLANES_DEF,
    parameter int NORMAL_FRAC_BITS = fpc_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // val_x, val_y, val_z, val_w, ext_x, ext_y, ext_z
    input  logic [fpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode, plane_index
    input  logic [fpc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // verdict, accepted, zero fill
    output logic [fpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int NORM_W  = NORMAL_FRAC_BITS + 2;
    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int CW      = fpc_pkg::COORD_W;

    // unpacked input fields
    logic [fpc_pkg::MODE_W-1:0]   mode;
    logic [fpc_pkg::INDEX_W-1:0]  plane_index;
    logic signed [CW-1:0]         val_x;
    logic signed [CW-1:0]         val_y;
    logic signed [CW-1:0]         val_z;
    logic signed [fpc_pkg::WVAL_W-1:0] val_w;
    logic signed [CW-1:0]         ext_x;
    logic signed [CW-1:0]         ext_y;
    logic signed [CW-1:0]         ext_z;

    logic                         load_en;
    logic [2:0][NORM_W-1:0]       load_normal;
    logic [PLANE_W-1:0]           plane_idx;
    logic [2:0][NORM_W-1:0]       plane_normal;
    logic signed [fpc_pkg::WVAL_W-1:0] plane_offset;

    fpc_pkg::mac_ctrl_t           mac_ctrl;
    fpc_pkg::mac_stat_t           mac_stat;
    logic signed [NORM_W-1:0]     mul_a;
    logic signed [CW-1:0]         mul_b;
    logic signed [fpc_pkg::WVAL_W-1:0] extra;

    logic [fpc_pkg::VERDICT_W-1:0] verdict;
    logic                          accepted;

    assign mode        = s_axis_tuser[fpc_pkg::MODE_W-1:0];
    assign plane_index = s_axis_tuser[fpc_pkg::MODE_W +: fpc_pkg::INDEX_W];
    assign val_x       = s_axis_tdata[0*CW +: CW];
    assign val_y       = s_axis_tdata[1*CW +: CW];
    assign val_z       = s_axis_tdata[2*CW +: CW];
    assign val_w       = s_axis_tdata[3*CW +: fpc_pkg::WVAL_W];
    assign ext_x       = s_axis_tdata[3*CW + fpc_pkg::WVAL_W +: CW];
    assign ext_y       = s_axis_tdata[4*CW + fpc_pkg::WVAL_W +: CW];
    assign ext_z       = s_axis_tdata[5*CW + fpc_pkg::WVAL_W +: CW];

    // a load transaction writes the plane in its accept cycle; normals keep
    // only their low bits, wrapping as two's complement
    assign load_en        = s_axis_tvalid && s_axis_tready && (mode == fpc_pkg::MODE_LOAD);
    assign load_normal[0] = val_x[NORM_W-1:0];
    assign load_normal[1] = val_y[NORM_W-1:0];
    assign load_normal[2] = val_z[NORM_W-1:0];

    fpc_plane_store #(
        .NUM_PLANES       (NUM_PLANES),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (load_en),
        .wr_idx    (plane_index),
        .wr_normal (load_normal),
        .wr_offset (val_w),
        .rd_idx    (plane_idx),
        .rd_normal (plane_normal),
        .rd_offset (plane_offset)
    );

    // sequencer walks the planes and feeds one term a cycle to the mac
    fpc_ctrl #(
        .NUM_PLANES       (NUM_PLANES),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .mode         (mode),
        .val_x        (val_x),
        .val_y        (val_y),
        .val_z        (val_z),
        .val_w        (val_w),
        .ext_x        (ext_x),
        .ext_y        (ext_y),
        .ext_z        (ext_z),
        .plane_idx    (plane_idx),
        .plane_normal (plane_normal),
        .mac_ctrl     (mac_ctrl),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .extra        (extra),
        .mac_stat     (mac_stat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .verdict      (verdict),
        .accepted     (accepted)
    );

    // exact dot product: offsets are shifted up by NORMAL_FRAC_BITS to the product scale
    fpc_mac #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .offset (plane_offset),
        .extra  (extra),
        .stat   (mac_stat)
    );

    assign m_axis_tdata = {(fpc_pkg::OUT_TDATA_W - fpc_pkg::VERDICT_W - 1)'(0),
                           accepted, verdict};

endmodule
